### rtl/ihtc_pkg.sv
package ihtc_pkg;

    // hash width and the part of the folded hash the color math needs
    localparam int HASH_W = 64;
    localparam int KEY_W  = 40;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;

    typedef logic [KEY_W-1:0] t_key;

    // input beat: one identifier byte
    typedef struct packed {
        logic [7:0] id_byte;
        logic       last;
    } t_in_beat;

    // output beat: one color
    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_out_beat;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### rtl/id_hash_track_color.sv
// id_hash_track_color: display color from an identifier hash
//
// input channel: one identifier byte per beat (i_in.id_byte), i_in.last
// marks the final byte. bytes are taken one per cycle into a running 64-bit
// fnv-1a hash, save a stalled last byte; a non-last byte is never stalled.
// output channel: one beat per identifier carrying red, green, blue as
// unsigned 16-bit fractions of full scale.
// the color unit handles one identifier at a time, in the steps queue pop,
// two multiplier steps and output load, run by its sequencer.
// a 2-entry queue sits between hashing and color math; the last byte of an
// identifier is stalled only while both entries are occupied.
// when the receiver stalls, the output beat holds and the color unit waits
// in its output step; bytes keep flowing, a last byte until the queue fills.
// reset: hash reloads the offset basis, queue empties, no output valid.
module id_hash_track_color #(
    parameter int COLOR_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ihtc_pkg::t_in_beat  i_in,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output ihtc_pkg::t_out_beat o_out,
    input  logic                i_out_stall
);
    import ihtc_pkg::*;

    t_q_status q_status;
    logic      push;
    t_key      push_key;
    logic      pop;
    t_key      pop_key;

    // hashing side
    ihtc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_in       (i_in),
        .o_stall    (o_in_stall),
        .i_q_status (q_status),
        .o_push     (push),
        .o_push_key (push_key)
    );

    // finished hashes waiting for color math
    ihtc_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_key (push_key),
        .i_pop      (pop),
        .o_pop_key  (pop_key),
        .o_status   (q_status)
    );

    // color side
    ihtc_back #(
        .FRAC_BITS (COLOR_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_key      (pop_key),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .o_out      (o_out),
        .i_stall    (i_out_stall)
    );

endmodule

### rtl/ihtc_fifo.sv
module ihtc_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ihtc_pkg::t_key     i_push_key,
    input  logic               i_pop,
    output ihtc_pkg::t_key     o_pop_key,
    output ihtc_pkg::t_q_status o_status
);
    import ihtc_pkg::*;

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    t_key          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_key;
        end
    end

    assign o_pop_key       = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == CW'(DEPTH));
    assign o_status.empty  = (r_count == '0);

    // no write into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == CW'(DEPTH)))
        else $error("push into full queue");

    // no read from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == '0))
        else $error("pop from empty queue");

endmodule

### rtl/ihtc_front.sv
module ihtc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ihtc_pkg::t_in_beat  i_in,
    output logic                o_stall,
    input  ihtc_pkg::t_q_status i_q_status,
    output logic                o_push,
    output ihtc_pkg::t_key      o_push_key
);
    import ihtc_pkg::*;

    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] mixed;
    logic [HASH_W-1:0] n_hash;
    logic              accept;

    // a last byte needs a free queue slot, other bytes always go
    assign o_stall = i_in.last && i_q_status.full;
    assign accept  = i_valid && !o_stall;

    // fold: xor the byte in, then times the prime 2^40 + 0x1b3, mod 2^64
    assign mixed  = r_hash ^ {{(HASH_W-8){1'b0}}, i_in.id_byte};
    assign n_hash = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
                  + (mixed << 4) + (mixed << 1) + mixed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
        end else if (accept) begin
            r_hash <= i_in.last ? FNV_BASIS : n_hash;
        end
    end

    // finished identifier goes to the queue
    assign o_push     = accept && i_in.last;
    assign o_push_key = n_hash[KEY_W-1:0];

    // a closed identifier leaves the basis behind
    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.last) |=> (r_hash == FNV_BASIS))
        else $error("hash not reloaded after last byte");

endmodule

### rtl/ihtc_back.sv
module ihtc_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ihtc_pkg::t_q_status i_q_status,
    input  ihtc_pkg::t_key      i_key,
    output logic                o_pop,
    output logic                o_valid,
    output ihtc_pkg::t_out_beat o_out,
    input  logic                i_stall
);
    import ihtc_pkg::*;

    localparam int F = FRAC_BITS;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL1 = 4'b0010,
        S_MUL2 = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state    r_state;
    logic      r_out_valid;
    t_out_beat r_out;

    logic [F-1:0] r_s;
    logic [F:0]   r_v;
    logic [F-1:0] r_f;
    logic [2:0]   r_sector;
    logic [F-1:0] r_sf;
    logic [F-1:0] r_sf1;
    logic [F:0]   r_oms;
    logic [F:0]   r_p;
    logic [F:0]   r_q;
    logic [F:0]   r_t;

    // saturation and value tables, one entry per hash byte
    logic [F-1:0] s_lut [256];
    logic [F:0]   v_lut [256];

    for (genvar i = 0; i < 256; i++) begin : g_lut
        assign s_lut[i] = F'((64'(663 + i) * (64'd1 << (F + 1)) + 64'd1020) / 64'd2040);
        assign v_lut[i] = (F+1)'((64'(4335 + 3 * i) * (64'd1 << (F + 1)) + 64'd5100)
                          / 64'd10200);
    end

    // hue times six: sector in the top bits, fraction below
    logic [26:0] hue6;
    assign hue6 = {1'b0, i_key[23:0], 2'b00} + {2'b00, i_key[23:0], 1'b0};

    // first products
    logic [2*F-1:0] sf_prod;
    logic [F:0]     omf;
    logic [2*F:0]   sf1_prod;
    assign sf_prod  = r_s * r_f;
    assign omf      = ONE - {1'b0, r_f};
    assign sf1_prod = r_s * omf;

    // second products
    logic [F:0]     omsf;
    logic [F:0]     omsf1;
    logic [2*F+1:0] p_prod;
    logic [2*F+1:0] q_prod;
    logic [2*F+1:0] t_prod;
    assign omsf   = ONE - {1'b0, r_sf};
    assign omsf1  = ONE - {1'b0, r_sf1};
    assign p_prod = r_v * r_oms;
    assign q_prod = r_v * omsf;
    assign t_prod = r_v * omsf1;

    // rescale to 16 fraction bits and clamp
    function automatic logic [15:0] to_q16(input logic [F:0] c);
        logic [F+16:0] w;
        w = {c, 16'd0} >> F;
        if (|w[F+16:16]) begin
            return 16'hFFFF;
        end
        return w[15:0];
    endfunction

    // sector table
    t_out_beat color;
    always_comb begin
        case (r_sector)
            3'd0: begin color.red = to_q16(r_v); color.green = to_q16(r_t);
                        color.blue = to_q16(r_p); end
            3'd1: begin color.red = to_q16(r_q); color.green = to_q16(r_v);
                        color.blue = to_q16(r_p); end
            3'd2: begin color.red = to_q16(r_p); color.green = to_q16(r_v);
                        color.blue = to_q16(r_t); end
            3'd3: begin color.red = to_q16(r_p); color.green = to_q16(r_q);
                        color.blue = to_q16(r_v); end
            3'd4: begin color.red = to_q16(r_t); color.green = to_q16(r_p);
                        color.blue = to_q16(r_v); end
            default: begin color.red = to_q16(r_v); color.green = to_q16(r_p);
                        color.blue = to_q16(r_q); end
        endcase
    end

    logic out_free;
    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_q_status.empty;

    // sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // output valid: set by the output step, cleared when the beat leaves
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_status.empty) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s      <= s_lut[i_key[31:24]];
            r_v      <= v_lut[i_key[39:32]];
            r_sector <= hue6[26:24];
            r_f      <= hue6[23 -: F];
        end
        if (r_state == S_MUL1) begin
            r_sf  <= sf_prod[2*F-1:F];
            r_sf1 <= sf1_prod[2*F-1:F];
            r_oms <= ONE - {1'b0, r_s};
        end
        if (r_state == S_MUL2) begin
            r_p <= p_prod[2*F:F];
            r_q <= q_prod[2*F:F];
            r_t <= t_prod[2*F:F];
        end
        if (r_state == S_OUT && out_free) begin
            r_out <= color;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // a new color only comes out of the output step
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("output valid raised outside output step");

endmodule
